// File: rtl/core/tcr_pkg.sv
// Package for the triad chord recognizer: pitch-class types, quality codes,
// triad templates and the small helper functions used by the front and back.
// No dependencies.
package tcr_pkg;

  localparam int PC_COUNT   = 12;
  localparam int FIFO_DEPTH = 2;

  typedef logic [6:0]          note_t;
  typedef logic [3:0]          pc_t;
  typedef logic [PC_COUNT-1:0] pc_mask_t;
  typedef logic [3:0]          pc_cnt_t;

  typedef enum logic [1:0] {
    QUAL_MAJOR = 2'd0,
    QUAL_MINOR = 2'd1,
    QUAL_DIM   = 2'd2,
    QUAL_AUG   = 2'd3
  } quality_t;

  // Root-position templates: bit k set for each interval k above the root.
  localparam pc_mask_t TPL_MAJOR = 12'h091;  // 0, 4, 7
  localparam pc_mask_t TPL_MINOR = 12'h089;  // 0, 3, 7
  localparam pc_mask_t TPL_DIM   = 12'h049;  // 0, 3, 6
  localparam pc_mask_t TPL_AUG   = 12'h111;  // 0, 4, 8

  // Finished chord mask handed from the front to the queue.
  typedef struct packed {
    logic     valid;
    pc_mask_t mask;
  } chord_push_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // note mod 12 through a reciprocal multiply: floor(note * 171 / 2048)
  // equals floor(note / 12) for every 7-bit note.
  function automatic pc_t pc_of(input note_t note);
    logic [14:0] prod;
    logic [3:0]  quo;
    logic [6:0]  rem;
    prod = 15'(note) * 15'd171;
    quo  = prod[14:11];
    rem  = note - 7'(quo * 4'd12);
    return rem[3:0];
  endfunction

  // Template of a given quality rotated up to a given root.
  function automatic pc_mask_t triad_mask(input int root, input quality_t qual);
    pc_mask_t           base;
    logic [2*PC_COUNT-1:0] wide;
    unique case (qual)
      QUAL_MAJOR: base = TPL_MAJOR;
      QUAL_MINOR: base = TPL_MINOR;
      QUAL_DIM:   base = TPL_DIM;
      QUAL_AUG:   base = TPL_AUG;
      default:    base = TPL_MAJOR;
    endcase
    wide = {{PC_COUNT{1'b0}}, base} << root;
    return wide[PC_COUNT-1:0] | wide[2*PC_COUNT-1:PC_COUNT];
  endfunction

  // Number of set bits in a 4-bit group.
  function automatic logic [2:0] nib_count(input logic [3:0] nib);
    return 3'(nib[0]) + 3'(nib[1]) + 3'(nib[2]) + 3'(nib[3]);
  endfunction

  // Number of pitch classes held in a mask.
  function automatic pc_cnt_t pc_count(input pc_mask_t m);
    return 4'(nib_count(m[3:0])) + 4'(nib_count(m[7:4])) + 4'(nib_count(m[11:8]));
  endfunction

endpackage

// File: rtl/core/tcr_if.sv
// Channel interfaces for the triad chord recognizer: note input and result output.
// Depends on tcr_pkg.
interface tcr_in_if
  import tcr_pkg::*;
;
  logic  valid;
  logic  ready;
  note_t note;
  logic  last;

  modport source (output valid, output note, output last, input ready);
  modport sink   (input valid, input note, input last, output ready);
endinterface

interface tcr_out_if
  import tcr_pkg::*;
;
  logic       valid;
  logic       ready;
  logic       found;
  logic [3:0] root;
  logic [1:0] quality;

  modport source (output valid, output found, output root, output quality, input ready);
  modport sink   (input valid, input found, input root, input quality, output ready);
endinterface

// File: rtl/core/tcr_front.sv
// Front of the triad chord recognizer: accepts notes and folds them into the
// held pitch-class mask; pushes the finished mask on the last note. Uses tcr_pkg.
module tcr_front
  import tcr_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  tcr_in_if.sink       in_ch,
  input  fifo_stat_t   stat_i,
  output chord_push_t  push_o
);

  pc_mask_t mask_r, mask_nxt;
  pc_mask_t merged;
  logic     accept;

  assign in_ch.ready = !stat_i.full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign merged      = mask_r | (pc_mask_t'(1) << pc_of(in_ch.note));

  always_comb begin
    mask_nxt = mask_r;
    if (accept) begin
      mask_nxt = in_ch.last ? '0 : merged;
    end
  end

  assign push_o.valid = accept && in_ch.last;
  assign push_o.mask  = merged;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else begin
      mask_r <= mask_nxt;
    end
  end

endmodule

// File: rtl/core/tcr_fifo.sv
// Two-entry queue of finished chord masks between front and back.
// Uses tcr_pkg.
module tcr_fifo
  import tcr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  chord_push_t push_i,
  input  logic        pop_i,
  output pc_mask_t    head_o,
  output fifo_stat_t  stat_o
);

  pc_mask_t   mem_r [FIFO_DEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push_en, pop_en;

  assign stat_o.full  = (cnt_r == 2'(FIFO_DEPTH));
  assign stat_o.empty = (cnt_r == 2'd0);
  assign push_en      = push_i.valid && !stat_o.full;
  assign pop_en       = pop_i && !stat_o.empty;
  assign head_o       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push_en ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop_en ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push_en) - 2'(pop_en);
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      mem_r[wr_ptr_r] <= push_i.mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // The front must never offer a chord into a full queue.
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    stat_o.full |-> !push_i.valid)
    else $error("chord pushed into full queue");

  // A lone push grows the fill count by one.
  a_cnt_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (push_en && !pop_en) |=> (cnt_r == $past(cnt_r) + 2'd1))
    else $error("queue count did not advance on push");

endmodule

// File: rtl/core/tcr_back.sv
// Back of the triad chord recognizer: takes one chord mask from the queue,
// searches the 48 triad templates and registers the result. Uses tcr_pkg.
module tcr_back
  import tcr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  pc_mask_t   head_i,
  input  fifo_stat_t stat_i,
  output logic       pop_o,
  tcr_out_if.source  out_ch
);

  logic       out_valid_r, out_valid_nxt;
  logic       found_r;
  logic [3:0] root_r;
  quality_t   quality_r;

  logic       hit;
  logic [3:0] hit_root;
  quality_t   hit_qual;
  pc_mask_t   tpl;
  logic       enough;

  // With exactly three classes, containment is the same as equality, so one
  // in-order containment search covers both passes.
  always_comb begin
    hit      = 1'b0;
    hit_root = '0;
    hit_qual = QUAL_MAJOR;
    tpl      = '0;
    for (int r = PC_COUNT - 1; r >= 0; r--) begin
      for (int q = 3; q >= 0; q--) begin
        tpl = triad_mask(r, quality_t'(q));
        if ((head_i & tpl) == tpl) begin
          hit      = 1'b1;
          hit_root = 4'(r);
          hit_qual = quality_t'(q);
        end
      end
    end
  end

  assign enough = (pc_count(head_i) >= 4'd3);
  assign pop_o  = !stat_i.empty && (!out_valid_r || out_ch.ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop_o) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_o) begin
      found_r   <= enough && hit;
      root_r    <= (enough && hit) ? hit_root : 4'd0;
      quality_r <= (enough && hit) ? hit_qual : QUAL_MAJOR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.found   = found_r;
  assign out_ch.root    = root_r;
  assign out_ch.quality = quality_r;

  // A miss reports root and quality as zero.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !found_r) |-> (root_r == 4'd0 && quality_r == QUAL_MAJOR))
    else $error("miss result carries nonzero fields");

  // A reported root is a real pitch class.
  a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (root_r < 4'(PC_COUNT)))
    else $error("root out of range");

endmodule

// File: rtl/core/triad_chord_recognizer_top.sv
// Triad chord recognizer, top level. Throughput: one note request per cycle while the chord
// queue is not full. A chord's mask is pushed into the queue as its last note is accepted;
// from the queue head it passes through the template search into the result register once
// that register is empty or being taken. Up to two chords wait in the queue beside
// the one held in the result register; notes stall only while the queue is full.
// Reset (rst_n, synchronous, active low) clears the held mask, queue and result valid.
module triad_chord_recognizer_top
  import tcr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  tcr_in_if.sink    in_ch,
  tcr_out_if.source out_ch
);

  chord_push_t push;
  fifo_stat_t  stat;
  pc_mask_t    head;
  logic        pop;

  // Front: fold each note request into the mask, push the mask on the last note.
  tcr_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .stat_i (stat),
    .push_o (push)
  );

  // Queue: decouple note intake from result delivery.
  tcr_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (push),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (stat)
  );

  // Back: search templates in root then quality order and hold the result.
  tcr_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head_i (head),
    .stat_i (stat),
    .pop_o  (pop),
    .out_ch (out_ch)
  );

endmodule

// File: tb/tb.sv
// Self-checking testbench for triad_chord_recognizer_top: streams chords as note
// requests, predicts each chord verdict and compares it with the result channel.
// Depends on tcr_pkg, tcr_in_if, tcr_out_if and the recognizer RTL.
module tb
  import tcr_pkg::*;
;

  // One note request as queued for the driver.
  typedef struct {
    note_t note;
    logic  last;
  } note_req_t;

  // Expected verdict of one finished chord.
  typedef struct {
    logic     found;
    pc_t      root;
    quality_t quality;
  } chord_verdict_t;

  localparam int RANDOM_NOTES = 1450;
  localparam int STALL_LIMIT  = 1000;  // cycles without any handshake
  localparam int SQUEEZE_AT   = 400;   // cycle at which the long receiver hold starts
  localparam int SQUEEZE_LEN  = 200;
  localparam int DRAIN_CYCLES = 8;

  logic clk;
  logic rst_n;

  tcr_in_if  in_ch ();
  tcr_out_if out_ch ();

  triad_chord_recognizer_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  note_req_t      note_backlog[$];     // requests not yet offered
  chord_verdict_t pending_verdicts[$]; // verdicts of chords whose result is still due
  pc_mask_t       chord_classes;       // pitch classes folded into the open chord
  int             fail_count;
  int             notes_queued;

  // Driver-side pacing.
  int src_wait;
  int src_calm;
  // Receiver-side pacing.
  int sink_wait;
  int sink_calm;
  int hold_left;
  int live_cycles;
  logic squeeze;   // set while the receiver holds off; the sender then stops idling
  // Watchdog.
  int idle_cycles;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Pitch-class mask of a triad of the given quality on the given root.
  function automatic pc_mask_t triad_shape(input int root, input quality_t qual);
    pc_mask_t shape;
    int       third;
    int       fifth;
    case (qual)
      QUAL_MAJOR: begin third = 4; fifth = 7; end
      QUAL_MINOR: begin third = 3; fifth = 7; end
      QUAL_DIM:   begin third = 3; fifth = 6; end
      default:    begin third = 4; fifth = 8; end
    endcase
    shape = '0;
    shape[root % PC_COUNT]           = 1'b1;
    shape[(root + third) % PC_COUNT] = 1'b1;
    shape[(root + fifth) % PC_COUNT] = 1'b1;
    return shape;
  endfunction

  // Verdict for a finished chord: exact triad first, then (only with more than
  // three classes) the first triad contained in the chord; scan roots upward and
  // within a root major, minor, diminished, augmented.
  function automatic chord_verdict_t classify_chord(input pc_mask_t held);
    chord_verdict_t verdict;
    pc_mask_t       shape;
    int             classes;
    verdict.found   = 1'b0;
    verdict.root    = '0;
    verdict.quality = QUAL_MAJOR;
    classes = $countones(held);
    if (classes >= 3) begin
      for (int r = 0; r < PC_COUNT; r++) begin
        for (int q = 0; q < 4; q++) begin
          shape = triad_shape(r, quality_t'(q));
          if (!verdict.found && shape == held) begin
            verdict.found   = 1'b1;
            verdict.root    = pc_t'(r);
            verdict.quality = quality_t'(q);
          end
        end
      end
      if (!verdict.found && classes > 3) begin
        for (int r = 0; r < PC_COUNT; r++) begin
          for (int q = 0; q < 4; q++) begin
            shape = triad_shape(r, quality_t'(q));
            if (!verdict.found && (held & shape) == shape) begin
              verdict.found   = 1'b1;
              verdict.root    = pc_t'(r);
              verdict.quality = quality_t'(q);
            end
          end
        end
      end
    end
    return verdict;
  endfunction

  // Fold one accepted note into the open chord; close the chord on its last note.
  task automatic fold_note(input note_t note, input logic last);
    chord_classes[note % PC_COUNT] = 1'b1;
    if (last) begin
      pending_verdicts.push_back(classify_chord(chord_classes));
      chord_classes = '0;
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d, expected %0d (t=%0t)", what, got, want, $realtime);
    fail_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Gap length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  // Random note of the given pitch class, any octave that fits in 7 bits.
  function automatic note_t note_of_class(input int pc);
    int top_octave;
    top_octave = (pc <= 7) ? 10 : 9;
    return note_t'(pc + 12 * $urandom_range(0, top_octave));
  endfunction

  task automatic add_note(input int note, input logic last);
    note_req_t req;
    req.note = note_t'(note);
    req.last = last;
    note_backlog.push_back(req);
    notes_queued++;
  endtask

  // Queue a shuffled chord and flag its final note.
  task automatic add_chord(input note_t notes[$]);
    note_t swap;
    int    j;
    for (int i = notes.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      swap = notes[i];
      notes[i] = notes[j];
      notes[j] = swap;
    end
    for (int i = 0; i < notes.size(); i++) add_note(notes[i], i == notes.size() - 1);
  endtask

  task automatic build_random_chords();
    note_t notes[$];
    int    kind;
    int    root;
    int    extra;
    pc_mask_t shape;
    while (notes_queued < RANDOM_NOTES) begin
      notes.delete();
      kind = $urandom_range(0, 99);
      if (kind < 75) begin
        // Well-formed triad in any voicing, sometimes doubled, sometimes with
        // added tones so the contained-triad search gets exercised.
        root  = $urandom_range(0, PC_COUNT - 1);
        shape = triad_shape(root, quality_t'($urandom_range(0, 3)));
        for (int pc = 0; pc < PC_COUNT; pc++) begin
          if (shape[pc]) notes.push_back(note_of_class(pc));
        end
        extra = $urandom_range(0, 2);
        for (int i = 0; i < extra; i++) notes.push_back(notes[$urandom_range(0, 2)]);
        if (kind >= 50) begin
          extra = $urandom_range(1, 3);
          for (int i = 0; i < extra; i++) notes.push_back(note_t'($urandom_range(0, 127)));
        end
      end else begin
        // Noise chord: random notes, from one note up to most of the octave.
        extra = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 6);
        for (int i = 0; i < extra; i++) notes.push_back(note_t'($urandom_range(0, 127)));
      end
      add_chord(notes);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Clock, reset and stimulus
  // ---------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.note    = '0;
    in_ch.last    = 1'b0;
    out_ch.ready  = 1'b0;
    squeeze       = 1'b0;
    chord_classes = '0;
    fail_count    = 0;
    notes_queued  = 0;
    src_wait      = 0;
    src_calm      = 0;
    sink_wait     = 0;
    sink_calm     = 0;
    hold_left     = 0;
    live_cycles   = 0;
    idle_cycles   = 0;

    // Lowest and highest note numbers inside a C major chord.
    add_note(0, 1'b0);
    add_note(127, 1'b0);
    add_note(4, 1'b1);
    // Single-note chord: one class, nothing found.
    add_note(127, 1'b1);
    // Octave doubling leaves only two classes: nothing found.
    add_note(60, 1'b0);
    add_note(72, 1'b0);
    add_note(67, 1'b1);
    // A minor, exact.
    add_note(69, 1'b0);
    add_note(72, 1'b0);
    add_note(76, 1'b1);
    // B diminished, wraps past the octave.
    add_note(71, 1'b0);
    add_note(74, 1'b0);
    add_note(77, 1'b1);
    // Augmented is symmetric: the lowest matching root wins.
    add_note(8, 1'b0);
    add_note(100, 1'b0);
    add_note(48, 1'b1);
    // Three clustered classes: no triad.
    add_note(0, 1'b0);
    add_note(1, 1'b0);
    add_note(2, 1'b1);
    // Dominant seventh: no exact match, contained C major is reported.
    add_note(48, 1'b0);
    add_note(52, 1'b0);
    add_note(55, 1'b0);
    add_note(58, 1'b1);

    build_random_chords();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: wait for every request to go out and every verdict to come back.
    while (note_backlog.size() != 0 || in_ch.valid || pending_verdicts.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: offer note requests from the backlog, with random gaps
  // ---------------------------------------------------------------------------

  note_req_t next_req;
  logic      next_valid;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.note  <= '0;
      in_ch.last  <= 1'b0;
    end else begin
      next_valid    = in_ch.valid;
      next_req.note = in_ch.note;
      next_req.last = in_ch.last;
      // Drop the request once it has been taken.
      if (in_ch.valid && in_ch.ready) next_valid = 1'b0;
      // Hold a waiting request; otherwise idle out the gap or advance.
      if (!next_valid) begin
        if (src_calm > 0) src_calm--;
        else if ($urandom_range(0, 149) == 0) src_calm = $urandom_range(40, 120);
        if (src_wait > 0 && !squeeze) begin
          src_wait--;
        end else if (note_backlog.size() != 0) begin
          next_req   = note_backlog.pop_front();
          next_valid = 1'b1;
          src_wait   = (src_calm > 0) ? 0 : pick_gap();
        end
      end
      in_ch.valid <= next_valid;
      in_ch.note  <= next_req.note;
      in_ch.last  <= next_req.last;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random back-pressure, plus one long hold so the chord queue fills
  // and the note input stalls
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      squeeze      <= 1'b0;
    end else begin
      live_cycles++;
      if (live_cycles == SQUEEZE_AT) hold_left = SQUEEZE_LEN;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
        squeeze      <= 1'b1;
      end else begin
        squeeze <= 1'b0;
        if (sink_calm > 0) sink_calm--;
        else if ($urandom_range(0, 149) == 0) sink_calm = $urandom_range(40, 120);
        if (sink_wait > 0) begin
          sink_wait--;
          out_ch.ready <= 1'b0;
        end else begin
          out_ch.ready <= 1'b1;
          sink_wait = (sink_calm > 0) ? 0 : pick_gap();
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check results against the oldest verdict, then fold accepted notes;
  // the watchdog ends the run when nothing moves for too long
  // ---------------------------------------------------------------------------

  chord_verdict_t want;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_verdicts.size() == 0) begin
          report_mismatch("result with no chord pending, found", out_ch.found, 0);
        end else begin
          want = pending_verdicts.pop_front();
          if (out_ch.found !== want.found)
            report_mismatch("found", out_ch.found, want.found);
          if (out_ch.root !== want.root)
            report_mismatch("root", out_ch.root, want.root);
          if (out_ch.quality !== want.quality)
            report_mismatch("quality", out_ch.quality, want.quality);
        end
      end
      if (in_ch.valid && in_ch.ready) fold_note(in_ch.note, in_ch.last);

      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("TIMEOUT: no handshake for %0d cycles, %0d verdicts pending",
                   idle_cycles, pending_verdicts.size());
          $display("simulation failed");
          $finish;
        end
      end
    end
  end

endmodule
